>>> design/las_pkg.sv
`timescale 1ns / 1ps

package las_pkg;

    localparam int DEF_GRID_W = 8;
    localparam int DEF_GRID_H = 8;

    localparam int COORD_W = 3;
    localparam int CFG_W   = 5;
    localparam int PHASE_W = 4;
    localparam int GEN_W   = 32;
    localparam int ACT_W   = 2;
    localparam int NB_W    = 3;

    localparam logic [CFG_W-1:0] DIV_RESET = CFG_W'(5);
    localparam logic [CFG_W-1:0] DIV_MAX   = CFG_W'(16);
    localparam logic [GEN_W-1:0] GEN_STEP  = GEN_W'(2);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_KEEP   = 2'd0,
        ACT_PAINT  = 2'd1,
        ACT_DARKEN = 2'd2
    } t_action;

    typedef struct packed {
        logic    alive;
        t_action action;
    } t_rule_res;

endpackage

>>> design/life_automaton_step_unit.sv
`timescale 1ns / 1ps

// Life (b3/s23) engine over a GRID_W x GRID_H grid, cells beyond the edge dead.
// Command channel: a word is taken when i_start is high and o_busy is low.
//   i_op load writes one cell (ignored outside the grid), busy in S_LD_RD/S_LD_WR.
//   i_op tick advances the frame phase modulo the divider; the remainder is
//   found by repeated subtraction in S_MOD.
// When the phase lands on divider - 1 the whole grid is stepped: the grid
// rows live in a synchronous memory, three rows sit in a window register and
// one cell is evaluated per cycle, so a step holds o_busy through the phase
// update, S_RD0 to S_RD2 and every cell of the grid.
// Each cell result is shown for one cycle with o_valid, in row order, in the
// cycle after it is evaluated; o_last marks the final cell. The receiver
// cannot stall the results.
// Config channel: i_cfg_valid/o_cfg_ready writes r_div_cfg, ready always.
// Reset (synchronous, active low) clears phase, generation count and the
// divider to 5; per-row valid bits make every row read as dead until written.
module life_automaton_step_unit #(
    parameter int GRID_W = las_pkg::DEF_GRID_W,
    parameter int GRID_H = las_pkg::DEF_GRID_H
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_op,
    input  logic [las_pkg::COORD_W-1:0]  i_load_x,
    input  logic [las_pkg::COORD_W-1:0]  i_load_y,
    input  logic                         i_load_alive,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [las_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    output logic [las_pkg::COORD_W-1:0]  o_cell_x,
    output logic [las_pkg::COORD_W-1:0]  o_cell_y,
    output logic                         o_alive,
    output logic [las_pkg::ACT_W-1:0]    o_action,
    output logic [las_pkg::GEN_W-1:0]    o_gen_count,
    output logic                         o_first_gen,
    output logic                         o_last
);
    import las_pkg::*;

    localparam int XW = $clog2(GRID_W);
    localparam int AW = $clog2(GRID_H);
    localparam int PW = GRID_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_MOD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_CELL
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_div_cfg;
    logic [CFG_W-1:0]     r_div;
    logic [CFG_W-1:0]     r_rem;
    logic [PHASE_W-1:0]   r_phase;
    logic [GEN_W-1:0]     r_gen;
    logic [XW-1:0]        r_x;
    logic [AW-1:0]        r_y;
    logic [XW-1:0]        r_ld_x;
    logic [AW-1:0]        r_ld_y;
    logic                 r_ld_alive;
    logic [GRID_W-1:0]    r_top;
    logic [GRID_W-1:0]    r_mid;
    logic [GRID_W-1:0]    r_bot;
    logic [GRID_W-1:0]    r_new_row;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic                 r_out_alive;
    t_action              r_out_act;
    logic [GEN_W-1:0]     r_out_gen;
    logic                 r_out_first;
    logic                 r_out_last;

    // row memory with one valid bit per row
    logic [GRID_W-1:0]    r_grid [GRID_H];
    logic [GRID_H-1:0]    r_row_valid;
    logic [GRID_W-1:0]    r_rd_data;
    logic                 r_rd_valid;

    logic                 mem_re;
    logic [AW-1:0]        mem_ra;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [GRID_W-1:0]    mem_wd;

    logic [GRID_W-1:0]    rd_row;
    logic [GRID_W-1:0]    ld_row;
    logic [GRID_W-1:0]    n_row;
    logic [CFG_W-1:0]     div_eff;
    logic                 x_last;
    logic                 y_last;
    logic                 bot_more;
    logic                 ld_in_grid;
    logic [PW-1:0]        pad_top;
    logic [PW-1:0]        pad_mid;
    logic [PW-1:0]        pad_bot;
    logic [NB_W-1:0]      nb_top;
    logic [NB_W-1:0]      nb_mid;
    logic [NB_W-1:0]      nb_bot;
    t_rule_res            rule_res;
    logic [COORD_W+XW-1:0] cx_ext;
    logic [COORD_W+AW-1:0] cy_ext;
    logic [COORD_W+XW-1:0] lx_ext;
    logic [COORD_W+AW-1:0] ly_ext;

    assign rd_row   = r_rd_valid ? r_rd_data : '0;
    assign x_last   = (r_x == XW'(GRID_W - 1));
    assign y_last   = (r_y == AW'(GRID_H - 1));
    assign bot_more = (r_y < AW'(GRID_H - 2));

    assign ld_in_grid = (32'(i_load_x) < GRID_W) && (32'(i_load_y) < GRID_H);
    assign lx_ext     = {{XW{1'b0}}, i_load_x};
    assign ly_ext     = {{AW{1'b0}}, i_load_y};
    assign cx_ext     = {{COORD_W{1'b0}}, r_x};
    assign cy_ext     = {{COORD_W{1'b0}}, r_y};

    always_comb begin
        div_eff = r_div_cfg;
        if (r_div_cfg == '0) begin
            div_eff = CFG_W'(1);
        end else if (r_div_cfg > DIV_MAX) begin
            div_eff = DIV_MAX;
        end
    end

    // neighborhood of the current cell, padded with dead cells at the edges
    assign pad_top = {1'b0, r_top, 1'b0};
    assign pad_mid = {1'b0, r_mid, 1'b0};
    assign pad_bot = {1'b0, r_bot, 1'b0};
    assign nb_top  = pad_top[r_x +: NB_W];
    assign nb_mid  = pad_mid[r_x +: NB_W];
    assign nb_bot  = pad_bot[r_x +: NB_W];

    las_rule u_rule (
        .i_top (nb_top),
        .i_mid (nb_mid),
        .i_bot (nb_bot),
        .o_res (rule_res)
    );

    always_comb begin
        n_row        = r_new_row;
        n_row[r_x]   = rule_res.alive;
        ld_row       = rd_row;
        ld_row[r_ld_x] = r_ld_alive;
    end

    // the window keeps old rows, so row y is written back in place while
    // row y+2 is fetched; loads are read-modify-write under o_busy
    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        unique case (r_state)
            S_LD_RD: begin
                mem_re = 1'b1;
                mem_ra = r_ld_y;
            end
            S_LD_WR: begin
                mem_we = 1'b1;
                mem_wa = r_ld_y;
                mem_wd = ld_row;
            end
            S_RD0: begin
                mem_re = 1'b1;
                mem_ra = '0;
            end
            S_RD1: begin
                mem_re = 1'b1;
                mem_ra = AW'(1);
            end
            S_CELL: begin
                mem_re = (r_x == '0) && bot_more;
                mem_ra = r_y + AW'(2);
                mem_we = x_last;
                mem_wa = r_y;
                mem_wd = n_row;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data  <= r_grid[mem_ra];
            r_rd_valid <= r_row_valid[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[mem_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cfg   <= DIV_RESET;
            r_phase     <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_div_cfg <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_op == OP_TICK) begin
                            r_div   <= div_eff;
                            r_rem   <= CFG_W'(r_phase) + CFG_W'(1);
                            r_state <= S_MOD;
                        end else if (ld_in_grid) begin
                            r_ld_x     <= lx_ext[XW-1:0];
                            r_ld_y     <= ly_ext[AW-1:0];
                            r_ld_alive <= i_load_alive;
                            r_state    <= S_LD_RD;
                        end
                    end
                end
                S_LD_RD: begin
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    r_state <= S_IDLE;
                end
                S_MOD: begin
                    // remainder by repeated subtraction
                    if (r_rem >= r_div) begin
                        r_rem <= r_rem - r_div;
                    end else begin
                        r_phase <= r_rem[PHASE_W-1:0];
                        if (r_rem == r_div - CFG_W'(1)) begin
                            r_state <= S_RD0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_mid   <= rd_row;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_top   <= '0;
                    r_bot   <= rd_row;
                    r_x     <= '0;
                    r_y     <= '0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_out_valid <= 1'b1;
                    r_out_x     <= cx_ext[COORD_W-1:0];
                    r_out_y     <= cy_ext[COORD_W-1:0];
                    r_out_alive <= rule_res.alive;
                    r_out_act   <= rule_res.action;
                    r_out_gen   <= r_gen;
                    r_out_first <= (r_gen == '0);
                    r_out_last  <= x_last && y_last;
                    r_new_row   <= n_row;
                    if (x_last) begin
                        r_x   <= '0;
                        r_top <= r_mid;
                        r_mid <= r_bot;
                        r_bot <= bot_more ? rd_row : '0;
                        if (y_last) begin
                            r_gen   <= r_gen + GEN_STEP;
                            r_state <= S_IDLE;
                        end else begin
                            r_y <= r_y + AW'(1);
                        end
                    end else begin
                        r_x <= r_x + XW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_alive     = r_out_alive;
    assign o_action    = r_out_act;
    assign o_gen_count = r_out_gen;
    assign o_first_gen = r_out_first;
    assign o_last      = r_out_last;

endmodule

>>> design/las_rule.sv
`timescale 1ns / 1ps

module las_rule (
    input  logic [las_pkg::NB_W-1:0] i_top,
    input  logic [las_pkg::NB_W-1:0] i_mid,
    input  logic [las_pkg::NB_W-1:0] i_bot,
    output las_pkg::t_rule_res       o_res
);
    import las_pkg::*;

    logic [3:0] count;
    logic       cur;

    always_comb begin
        count = 4'd0;
        for (int i = 0; i < NB_W; i++) begin
            count = count + 4'(i_top[i]) + 4'(i_bot[i]);
        end
        count = count + 4'(i_mid[0]) + 4'(i_mid[2]);
    end

    assign cur = i_mid[1];

    // b3/s23, anything else goes dark
    always_comb begin
        if (count < 4'd2) begin
            o_res = '{alive: 1'b0, action: ACT_DARKEN};
        end else if (cur && count > 4'd3) begin
            o_res = '{alive: 1'b0, action: ACT_DARKEN};
        end else if (!cur && count == 4'd3) begin
            o_res = '{alive: 1'b1, action: ACT_PAINT};
        end else if (!cur) begin
            o_res = '{alive: 1'b0, action: ACT_DARKEN};
        end else begin
            o_res = '{alive: 1'b1, action: ACT_KEEP};
        end
    end

endmodule

>>> design/las_chk.sv
`timescale 1ns / 1ps

module las_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_busy,
    input logic                         o_valid,
    input logic [las_pkg::GEN_W-1:0]    o_gen_count,
    input logic                         o_first_gen,
    input logic                         o_last
);
    import las_pkg::*;

    // a result word only follows a cycle of work
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result word without preceding busy cycle");

    // cells of one step come back to back up to the last one
    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a step burst");

    // generation count holds across a step
    a_gen_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> $stable(o_gen_count))
        else $error("generation count changed inside a step");

    a_first_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_gen == (o_gen_count == '0)))
        else $error("first_gen disagrees with generation count");

endmodule

bind life_automaton_step_unit las_chk u_las_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_gen_count (o_gen_count),
    .o_first_gen (o_first_gen),
    .o_last      (o_last)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import las_pkg::*;

    localparam int GW            = DEF_GRID_W;
    localparam int GH            = DEF_GRID_H;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 100;
    localparam int PHASE_ITEMS   = 22;
    localparam int NUM_PHASES    = 12;

    typedef struct {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               alive;
    } t_cmd;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               alive;
        t_action            act;
        logic [GEN_W-1:0]   gen;
        logic               first;
        logic               last;
    } t_cell_report;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               op = OP_LOAD;
    logic [COORD_W-1:0] load_x = '0;
    logic [COORD_W-1:0] load_y = '0;
    logic               load_alive = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               res_valid;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_alive;
    logic [ACT_W-1:0]   action;
    logic [GEN_W-1:0]   gen_count;
    logic               first_gen;
    logic               last;

    // predicted block state
    logic             life_grid [GH][GW];
    logic [PHASE_W-1:0] frame_phase_q = '0;
    logic [GEN_W-1:0] gen_q = '0;
    logic [CFG_W-1:0] divider_q = DIV_RESET;

    t_cmd         pending_cmds[$];
    t_cell_report expected_cells[$];

    bit took_item = 1'b0;
    bit steady = 1'b0;
    int gap_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int items_taken = 0;
    int cells_seen = 0;
    int steps_predicted = 0;
    int divider_writes = 0;
    int queued_total = 0;

    life_automaton_step_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_op         (op),
        .i_load_x     (load_x),
        .i_load_y     (load_y),
        .i_load_alive (load_alive),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_valid      (res_valid),
        .o_cell_x     (cell_x),
        .o_cell_y     (cell_y),
        .o_alive      (cell_alive),
        .o_action     (action),
        .o_gen_count  (gen_count),
        .o_first_gen  (first_gen),
        .o_last       (last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        for (int y = 0; y < GH; y++) begin
            for (int x = 0; x < GW; x++) begin
                life_grid[y][x] = 1'b0;
            end
        end
    end

    function automatic int effective_divider(logic [CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > DIV_MAX) return int'(DIV_MAX);
        return int'(d);
    endfunction

    function automatic int count_neighbours(int x, int y);
        int n;
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                if ((dx != 0 || dy != 0) && x + dx >= 0 && y + dy >= 0 &&
                    x + dx < GW && y + dy < GH) begin
                    n += life_grid[y + dy][x + dx] ? 1 : 0;
                end
            end
        end
        return n;
    endfunction

    task automatic step_generation();
        logic         next_grid [GH][GW];
        t_cell_report r;
        int           n;
        logic         cur;
        for (int y = 0; y < GH; y++) begin
            for (int x = 0; x < GW; x++) begin
                n = count_neighbours(x, y);
                cur = life_grid[y][x];
                if (n < 2 || (cur && n > 3)) begin
                    r.alive = 1'b0;
                    r.act = ACT_DARKEN;
                end else if (!cur && n == 3) begin
                    r.alive = 1'b1;
                    r.act = ACT_PAINT;
                end else if (!cur) begin
                    r.alive = 1'b0;
                    r.act = ACT_DARKEN;
                end else begin
                    r.alive = 1'b1;
                    r.act = ACT_KEEP;
                end
                next_grid[y][x] = r.alive;
                r.x = COORD_W'(x);
                r.y = COORD_W'(y);
                r.gen = gen_q;
                r.first = (gen_q == 0);
                r.last = (x == GW - 1 && y == GH - 1);
                expected_cells.push_back(r);
            end
        end
        life_grid = next_grid;
        gen_q = gen_q + GEN_STEP;
        steps_predicted++;
    endtask

    task automatic apply_cmd(t_cmd c);
        int div;
        if (c.op == OP_LOAD) begin
            if (c.x < GW && c.y < GH) life_grid[c.y][c.x] = c.alive;
        end else begin
            div = effective_divider(divider_q);
            frame_phase_q = PHASE_W'((frame_phase_q + 1) % div);
            if (int'(frame_phase_q) == div - 1) step_generation();
        end
    endtask

    // monitor: results, divider writes and accepted command words
    always @(posedge clk) begin
        t_cell_report e;
        t_cmd         c;
        took_item = 1'b0;
        if (rst_n) begin
            if (res_valid) begin
                cells_seen++;
                if (expected_cells.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: x=%0d y=%0d alive=%0d act=%0d",
                                 cell_x, cell_y, cell_alive, action);
                    mismatches++;
                end else begin
                    e = expected_cells.pop_front();
                    if (cell_x !== e.x || cell_y !== e.y || cell_alive !== e.alive ||
                        action !== e.act || gen_count !== e.gen ||
                        first_gen !== e.first || last !== e.last) begin
                        if (mismatches < 10) begin
                            $display(
                                "exp: x=%0d y=%0d alive=%0d act=%0d gen=%0d first=%0d last=%0d",
                                e.x, e.y, e.alive, e.act, e.gen, e.first, e.last);
                            $display(
                                "got: x=%0d y=%0d alive=%0d act=%0d gen=%0d first=%0d last=%0d",
                                cell_x, cell_y, cell_alive, action, gen_count,
                                first_gen, last);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                divider_q = cfg_data;
                divider_writes++;
            end
            if (start && !busy) begin
                took_item = 1'b1;
                c.op = op;
                c.x = load_x;
                c.y = load_y;
                c.alive = load_alive;
                apply_cmd(c);
                items_taken++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: one command word at a time, random gaps after a word is taken
    always @(negedge clk) begin
        t_cmd c;
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                op <= c.op;
                load_x <= c.x;
                load_y <= c.y;
                load_alive <= c.alive;
                start <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 14);
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic queue_cmd(logic o, int x, int y, logic a);
        t_cmd c;
        c.op = o;
        c.x = COORD_W'(x);
        c.y = COORD_W'(y);
        c.alive = a;
        pending_cmds.push_back(c);
        queued_total++;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_cmds.size() != 0 || start || expected_cells.size() != 0);
        // a tick without a step may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_divider(logic [CFG_W-1:0] d);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_phase(int div);
        int target;
        int density;
        target = queued_total + PHASE_ITEMS;
        while (queued_total < target) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: loads and ticks mixed at random
                repeat ($urandom_range(3, 10))
                    queue_cmd($urandom_range(0, 1), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom_range(0, 1));
            end else begin
                // seed a pattern, then tick through up to two steps
                density = $urandom_range(15, 85);
                repeat ($urandom_range(2, 12))
                    queue_cmd(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 99) < density);
                repeat ($urandom_range(1, 2 * div))
                    queue_cmd(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] plan [7];
        logic [CFG_W-1:0] d;
        plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners with no neighbours die
        queue_cmd(OP_LOAD, 0, 0, 1'b1);
        queue_cmd(OP_LOAD, GW - 1, 0, 1'b1);
        queue_cmd(OP_LOAD, 0, GH - 1, 1'b1);
        queue_cmd(OP_LOAD, GW - 1, GH - 1, 1'b1);
        // plus shape: center is overcrowded, arms give births and survivals
        queue_cmd(OP_LOAD, 3, 2, 1'b1);
        queue_cmd(OP_LOAD, 3, 3, 1'b1);
        queue_cmd(OP_LOAD, 3, 4, 1'b1);
        queue_cmd(OP_LOAD, 4, 3, 1'b1);
        queue_cmd(OP_LOAD, 2, 3, 1'b1);
        // still block near a corner
        queue_cmd(OP_LOAD, 5, 5, 1'b1);
        queue_cmd(OP_LOAD, 6, 5, 1'b1);
        queue_cmd(OP_LOAD, 5, 6, 1'b1);
        queue_cmd(OP_LOAD, 6, 6, 1'b1);
        queue_cmd(OP_LOAD, GW - 1, GH - 1, 1'b0);
        // reset divider: the fourth tick steps, then every fifth
        repeat (9) queue_cmd(OP_TICK, 7, 7, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 7)
                d = plan[p];
            else if (p == 7)
                d = CFG_W'($urandom_range(0, 31));
            else
                d = CFG_W'($urandom_range(1, 5));
            if (p >= NUM_PHASES - 2) steady = 1'b1;
            write_divider(d);
            queue_random_phase(effective_divider(d));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d command words, %0d generation steps, %0d cell results checked",
                 items_taken, steps_predicted, cells_seen);
        $display("%0d divider writes, %0d mismatches, %0d results still owed",
                 divider_writes, mismatches, expected_cells.size());
        if (mismatches == 0 && expected_cells.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> life_automaton_step_unit.f
design/las_pkg.sv
design/las_rule.sv
design/life_automaton_step_unit.sv
design/las_chk.sv
sim/tb.sv
